>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the scan code decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/scd_pkg.sv
// Types, key codes and character table of the scan code decoder.
`default_nettype none

package scd_pkg;

	localparam int SHELL_COUNT_DEF = 4;
	localparam int FLAG_W          = 4;

	localparam logic [7:0] KEY_DIGIT1  = 8'h02;
	localparam logic [7:0] KEY_LSHIFT  = 8'h2A;
	localparam logic [7:0] KEY_RSHIFT  = 8'h36;
	localparam logic [7:0] KEY_CAPS    = 8'h3A;
	localparam logic [7:0] KEY_ALT     = 8'h38;
	localparam logic [7:0] KEY_ACCENT  = 8'h28;
	localparam logic [7:0] REL_LSHIFT  = 8'hAA;
	localparam logic [7:0] REL_RSHIFT  = 8'hB6;
	localparam logic [7:0] REL_ALT     = 8'hB8;
	localparam logic [7:0] CHR_ACCENT  = 8'h27;
	localparam logic [7:0] CHR_NONE    = 8'h00;
	localparam logic [7:0] CHR_A_ACUTE = 8'd160;
	localparam logic [7:0] CHR_E_ACUTE = 8'd130;
	localparam logic [7:0] CHR_I_ACUTE = 8'd161;
	localparam logic [7:0] CHR_O_ACUTE = 8'd162;
	localparam logic [7:0] CHR_U_ACUTE = 8'd163;

	typedef struct packed {
		logic shift;
		logic caps;
		logic alt;
		logic accent;
	} flags_t;

	typedef struct packed {
		logic [1:0] n;
		logic [7:0] char0;
		logic [7:0] char1;
		logic       shell;
	} res_t;

	function automatic logic is_alpha(input logic [6:0] key);
		return (key >= 7'h10 && key <= 7'h19) || (key >= 7'h1E && key <= 7'h26) ||
			(key >= 7'h2C && key <= 7'h32);
	endfunction

	function automatic logic [7:0] accented(input logic [6:0] key);
		logic [7:0] v;
		unique case (key)
			7'h1E:   v = CHR_A_ACUTE;
			7'h12:   v = CHR_E_ACUTE;
			7'h17:   v = CHR_I_ACUTE;
			7'h18:   v = CHR_O_ACUTE;
			7'h16:   v = CHR_U_ACUTE;
			default: v = CHR_NONE;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] both(input logic col, input logic [7:0] a,
		input logic [7:0] b);
		return col ? b : a;
	endfunction

	function automatic logic [7:0] pick(input logic [1:0] sel, input logic [7:0] a0,
		input logic [7:0] a1, input logic [7:0] b0, input logic [7:0] b1);
		return sel[1] ? (sel[0] ? b1 : b0) : (sel[0] ? a1 : a0);
	endfunction

	function automatic logic [7:0] letter(input logic col, input logic [7:0] lc);
		return col ? (lc - 8'h20) : lc;
	endfunction

	function automatic logic [7:0] key_char(input logic layout, input logic [6:0] key,
		input logic col);
		logic [1:0] s;
		logic [7:0] v;
		s = {layout, col};
		unique case (key)
			7'h02:   v = both(col, 8'h31, 8'h21);
			7'h03:   v = pick(s, 8'h32, 8'h40, 8'h32, 8'h22);
			7'h04:   v = both(col, 8'h33, 8'h23);
			7'h05:   v = both(col, 8'h34, 8'h24);
			7'h06:   v = both(col, 8'h35, 8'h25);
			7'h07:   v = pick(s, 8'h36, 8'h5E, 8'h36, 8'h26);
			7'h08:   v = pick(s, 8'h37, 8'h26, 8'h37, 8'h2F);
			7'h09:   v = pick(s, 8'h38, 8'h2A, 8'h38, 8'h28);
			7'h0A:   v = pick(s, 8'h39, 8'h28, 8'h39, 8'h29);
			7'h0B:   v = pick(s, 8'h30, 8'h29, 8'h30, 8'h3D);
			7'h0C:   v = pick(s, 8'h2D, 8'h5F, 8'h20, 8'h3F);
			7'h0D:   v = pick(s, 8'h3D, 8'h2B, 8'h20, 8'h20);
			7'h0E:   v = 8'h08;
			7'h10:   v = letter(col, 8'h71);
			7'h11:   v = letter(col, 8'h77);
			7'h12:   v = letter(col, 8'h65);
			7'h13:   v = letter(col, 8'h72);
			7'h14:   v = letter(col, 8'h74);
			7'h15:   v = letter(col, 8'h79);
			7'h16:   v = letter(col, 8'h75);
			7'h17:   v = letter(col, 8'h69);
			7'h18:   v = letter(col, 8'h6F);
			7'h19:   v = letter(col, 8'h70);
			7'h1A:   v = pick(s, 8'h5B, 8'h7B, 8'h60, 8'h5B);
			7'h1B:   v = pick(s, 8'h5D, 8'h7D, 8'h2B, 8'h5D);
			7'h1C:   v = 8'h0A;
			7'h1E:   v = letter(col, 8'h61);
			7'h1F:   v = letter(col, 8'h73);
			7'h20:   v = letter(col, 8'h64);
			7'h21:   v = letter(col, 8'h66);
			7'h22:   v = letter(col, 8'h67);
			7'h23:   v = letter(col, 8'h68);
			7'h24:   v = letter(col, 8'h6A);
			7'h25:   v = letter(col, 8'h6B);
			7'h26:   v = letter(col, 8'h6C);
			7'h27:   v = pick(s, 8'h3B, 8'h3A, 8'hA4, 8'hA5);
			7'h28:   v = pick(s, 8'h27, 8'h22, 8'h27, 8'h7D);
			7'h29:   v = pick(s, 8'h60, 8'h7E, 8'h3C, 8'h3E);
			7'h2B:   v = pick(s, 8'h5C, 8'h7C, 8'h3C, 8'h3E);
			7'h2C:   v = letter(col, 8'h7A);
			7'h2D:   v = letter(col, 8'h78);
			7'h2E:   v = letter(col, 8'h63);
			7'h2F:   v = letter(col, 8'h76);
			7'h30:   v = letter(col, 8'h62);
			7'h31:   v = letter(col, 8'h6E);
			7'h32:   v = letter(col, 8'h6D);
			7'h33:   v = pick(s, 8'h2C, 8'h3C, 8'h2C, 8'h3B);
			7'h34:   v = pick(s, 8'h2E, 8'h3E, 8'h2E, 8'h3A);
			7'h35:   v = pick(s, 8'h2F, 8'h3F, 8'h2D, 8'h5F);
			7'h37:   v = 8'h2A;
			7'h39:   v = 8'h20;
			7'h4B:   v = 8'h96;
			7'h4D:   v = 8'h9A;
			7'h55:   v = both(col, 8'h2B, 8'h2A);
			7'h56:   v = both(col, 8'h2B, 8'h2A);
			default: v = CHR_NONE;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/scd_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module scd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/scd_decode.sv
// Key decode: next modifier flags and the characters caused by one scan code.
`default_nettype none

module scd_decode #(
	parameter int SHELL_COUNT = scd_pkg::SHELL_COUNT_DEF
) (
	input  wire logic [7:0]     code,
	input  wire logic           layout,
	input  wire scd_pkg::flags_t cur,
	output scd_pkg::flags_t     nxt,
	output scd_pkg::res_t       res
);

	localparam logic [8:0] SHELL_LIMIT = 9'(32'(scd_pkg::KEY_DIGIT1) + SHELL_COUNT);

	logic [6:0] key;
	logic       sx;
	logic       shell_hit;
	logic       skip;
	logic [7:0] acc_v;
	logic [7:0] rom_ch;

	assign key       = code[6:0];
	assign sx        = cur.shift ^ cur.caps;
	assign shell_hit = cur.alt && (code >= scd_pkg::KEY_DIGIT1) &&
		({1'b0, code} < SHELL_LIMIT);
	assign acc_v     = scd_pkg::accented(key);
	assign rom_ch    = scd_pkg::key_char(layout, key,
		scd_pkg::is_alpha(key) ? sx : cur.shift);

	always_comb begin
		nxt       = cur;
		res       = '0;
		skip      = 1'b0;
		priority if (code[7]) begin
			if (code == scd_pkg::REL_LSHIFT || code == scd_pkg::REL_RSHIFT) begin
				nxt.shift = 1'b0;
			end else if (code == scd_pkg::REL_ALT) begin
				nxt.alt = 1'b0;
			end
		end else if (code == scd_pkg::KEY_LSHIFT || code == scd_pkg::KEY_RSHIFT) begin
			nxt.shift = 1'b1;
		end else if (code == scd_pkg::KEY_CAPS) begin
			nxt.caps = ~cur.caps;
		end else if (code == scd_pkg::KEY_ALT) begin
			nxt.alt = 1'b1;
		end else if (code == scd_pkg::KEY_ACCENT && layout) begin
			nxt.accent = 1'b1;
		end else begin
			res.shell = shell_hit;
			if (cur.accent && layout) begin
				nxt.accent = 1'b0;
				if (!sx) begin
					res.n = 2'd1;
					if (acc_v != scd_pkg::CHR_NONE) begin
						res.char0 = acc_v;
						skip      = 1'b1;
					end else begin
						res.char0 = scd_pkg::CHR_ACCENT;
					end
				end
			end
			if (!skip && rom_ch != scd_pkg::CHR_NONE) begin
				if (res.n == 2'd0) begin
					res.char0 = rom_ch;
					res.n     = 2'd1;
				end else begin
					res.char1 = rom_ch;
					res.n     = 2'd2;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/scd_out_buf.sv
// Two-deep result buffer feeding the character channel.
`default_nettype none
`include "assert_macros.svh"

module scd_out_buf (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire scd_pkg::res_t res,
	output logic            free,
	output logic            char_valid,
	input  wire logic       char_stall,
	output logic      [7:0] char_code,
	output logic            last,
	output logic            shell_request
);

	logic       head_valid_q;
	logic [7:0] head_char_q;
	logic       head_last_q;
	logic       head_shell_q;
	logic       tail_valid_q;
	logic [7:0] tail_char_q;
	logic       tail_shell_q;
	logic       pop;

	assign pop  = head_valid_q && !char_stall;
	assign free = !head_valid_q || (pop && !tail_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			tail_valid_q <= 1'b0;
		end else if (push) begin
			head_valid_q <= 1'b1;
			tail_valid_q <= (res.n == 2'd2);
		end else if (pop) begin
			head_valid_q <= tail_valid_q;
			tail_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			head_char_q  <= res.char0;
			head_last_q  <= (res.n == 2'd1);
			head_shell_q <= res.shell;
			tail_char_q  <= res.char1;
			tail_shell_q <= res.shell;
		end else if (pop && tail_valid_q) begin
			head_char_q  <= tail_char_q;
			head_last_q  <= 1'b1;
			head_shell_q <= tail_shell_q;
		end
	end

	assign char_valid    = head_valid_q;
	assign char_code     = head_char_q;
	assign last          = head_last_q;
	assign shell_request = head_shell_q;

	`ASSERT_ALWAYS(a_tail_has_head, !tail_valid_q || head_valid_q, "tail without head")
	`ASSERT_ALWAYS(a_push_when_free, !push || free, "push into full buffer")
	`ASSERT_NEXT(a_pair_held, push && res.n == 2'd2, head_valid_q && tail_valid_q,
		"second character lost")

endmodule

`default_nettype wire

>>> rtl/scan_code_to_char_decoder.sv
// Top level of the scan code to character decoder.
// Usage:
//   Scan channel: scan_valid / scan_stall / key_code. A request is taken at a
//   rising edge with scan_valid high and scan_stall low.
//   Character channel: char_valid / char_stall with char_code, last and
//   shell_request. A request is taken when char_valid is high and char_stall low.
//   layout_select_we writes layout_select (0 US, 1 Spanish with dead accent);
//   write it only while the block is idle.
//   Scan codes are registered in the decode stage, characters in the result buffer.
//   Throughput: one scan code per cycle if it yields no character, or one
//   character while char_stall is low; one that yields an accent character plus
//   its own character holds the next in the decode stage until both are taken.
//   Modifier flags live in a one-entry RAM read at accept and written back when
//   the decode stage fires; a write in the same cycle as the next read is forwarded.
//   Reset clears the flags (the RAM entry reads as zero until first written),
//   the layout and all valid bits. When char_stall holds, the result buffer
//   fills, then scan_stall rises and the decode stage holds its scan code.
`default_nettype none
`include "assert_macros.svh"

module scan_code_to_char_decoder #(
	parameter int SHELL_COUNT = scd_pkg::SHELL_COUNT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       layout_select_we,
	input  wire logic       layout_select,
	input  wire logic       scan_valid,
	output logic            scan_stall,
	input  wire logic [7:0] key_code,
	output logic            char_valid,
	input  wire logic       char_stall,
	output logic      [7:0] char_code,
	output logic            last,
	output logic            shell_request
);

	logic                          layout_q;
	logic                          mem_init_q;
	logic                          valid_s1;
	logic [7:0]                    code_s1;
	logic                          init_s1;
	logic                          fwd_valid_s1;
	scd_pkg::flags_t               fwd_flags_s1;
	logic [scd_pkg::FLAG_W-1:0]    rd_data;
	scd_pkg::flags_t               cur_flags;
	scd_pkg::flags_t               nxt_flags;
	scd_pkg::res_t                 res;
	logic                          buf_free;
	logic                          fire;
	logic                          accept;

	assign fire       = valid_s1 && (res.n == 2'd0 || buf_free);
	assign scan_stall = valid_s1 && !fire;
	assign accept     = scan_valid && !scan_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b0;
		end else if (layout_select_we) begin
			layout_q <= layout_select;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_init_q   <= 1'b0;
			valid_s1     <= 1'b0;
			init_s1      <= 1'b0;
			fwd_valid_s1 <= 1'b0;
		end else begin
			if (fire) begin
				mem_init_q <= 1'b1;
			end
			if (accept) begin
				valid_s1     <= 1'b1;
				init_s1      <= mem_init_q;
				fwd_valid_s1 <= fire;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1      <= key_code;
			fwd_flags_s1 <= nxt_flags;
		end
	end

	scd_ram #(
		.WIDTH (scd_pkg::FLAG_W),
		.DEPTH (1)
	) u_flag_ram (
		.clk   (clk),
		.we    (fire),
		.waddr (1'b0),
		.wdata (nxt_flags),
		.re    (accept),
		.raddr (1'b0),
		.rdata (rd_data)
	);

	always_comb begin
		priority if (fwd_valid_s1) begin
			cur_flags = fwd_flags_s1;
		end else if (init_s1) begin
			cur_flags = scd_pkg::flags_t'(rd_data);
		end else begin
			cur_flags = '0;
		end
	end

	scd_decode #(
		.SHELL_COUNT (SHELL_COUNT)
	) u_decode (
		.code   (code_s1),
		.layout (layout_q),
		.cur    (cur_flags),
		.nxt    (nxt_flags),
		.res    (res)
	);

	scd_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (fire && res.n != 2'd0),
		.res           (res),
		.free          (buf_free),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_code     (char_code),
		.last          (last),
		.shell_request (shell_request)
	);

	`ASSERT_ALWAYS(a_stall_needs_item, !scan_stall || valid_s1, "stall with empty decode stage")
	`ASSERT_NEXT(a_s1_hold, valid_s1 && !fire, valid_s1 && $stable(code_s1),
		"decode stage lost its scan code")

endmodule

`default_nettype wire
